/* rtl/lfbe_pkg.sv */
// Package for the LANC frame bit engine: item structs, config struct,
// phase enum, line action codes and frame constants. No dependencies.
package lfbe_pkg;

    localparam int FRAME_BYTES      = 8;
    localparam int TX_BYTES         = 2;
    localparam int BYTE_BITS        = 8;
    localparam int FRAME_BITS       = FRAME_BYTES * BYTE_BITS;
    localparam int TX_BITS          = TX_BYTES * BYTE_BITS;
    localparam int STOP_BIT_NUM     = BYTE_BITS + 1;
    localparam int BIT_INDEX_W      = 7;
    localparam int ELAPSED_W        = 16;
    localparam int TX_WORD_W        = 16;
    localparam int RX_WORD_W        = 32;
    localparam int CFG_DATA_W       = 16;
    localparam int CFG_INDEX_W      = 2;

    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;

    localparam logic [CFG_INDEX_W-1:0] REG_BIT_TIME      = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_HALF_BIT_TIME = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_BYTE_TIME     = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SYNC_GAP      = 2'd3;

    localparam logic [9:0]  RST_BIT_TIME      = 10'd104;
    localparam logic [8:0]  RST_HALF_BIT_TIME = 9'd52;
    localparam logic [11:0] RST_BYTE_TIME     = 12'd1200;
    localparam logic [15:0] RST_SYNC_GAP      = 16'd3000;

    localparam logic [1:0] ACT_NONE = 2'd0;
    localparam logic [1:0] ACT_ONE  = 2'd1;
    localparam logic [1:0] ACT_ZERO = 2'd2;
    localparam logic [1:0] ACT_IDLE = 2'd3;

    typedef enum logic [2:0] {
        PH_SEARCH     = 3'd0,
        PH_WAIT_START = 3'd1,
        PH_TX_BIT     = 3'd2,
        PH_TX_STOP    = 3'd3,
        PH_WAIT_NEXT  = 3'd4,
        PH_RX_BIT     = 3'd5
    } t_phase;

    typedef struct packed {
        logic        line_level;
        logic [15:0] command_word;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  line_action;
        logic        frame_done;
        logic [31:0] reply_data;
    } t_out_item;

    typedef struct packed {
        logic [9:0]  bit_time;
        logic [8:0]  half_bit_time;
        logic [11:0] byte_time;
        logic [15:0] sync_gap;
    } t_cfg;

endpackage

/* rtl/lanc_frame_bit_engine_top.sv */
// Top level of the LANC frame bit engine: config registers, phase machine
// and result register. Depends on lfbe_pkg, lfbe_cfg, lfbe_core, lfbe_out_stage.
//
// One input item is one microsecond tick carrying the sampled line level and
// the pending command word; every tick yields exactly one result item with
// the line action, a frame-done flag and the 32-bit reply (bytes 4..7).
// The phase machine updates its state at the accepting edge and the result
// lands in the output register, so a new item is taken every cycle unless a
// full output register is stalled. Results appear in the cycle after
// acceptance. Write configuration only while idle.
module lanc_frame_bit_engine_top
    import lfbe_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  t_in_item               i_in_item,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output t_out_item              o_out_item,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    t_cfg      w_cfg;
    t_out_item w_result;
    logic      w_accept;

    assign o_in_stall = o_out_valid & i_out_stall;
    assign w_accept   = i_in_valid & ~o_in_stall;

    lfbe_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    lfbe_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_accept),
        .i_item   (i_in_item),
        .i_cfg    (w_cfg),
        .o_result (w_result)
    );

    lfbe_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_accept),
        .i_item  (w_result),
        .i_stall (i_out_stall),
        .o_valid (o_out_valid),
        .o_item  (o_out_item)
    );

endmodule

/* rtl/lfbe_cfg.sv */
// Configuration registers of the LANC frame bit engine.
// Depends on lfbe_pkg.
module lfbe_cfg
    import lfbe_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    output t_cfg                   o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.bit_time      <= RST_BIT_TIME;
            r_cfg.half_bit_time <= RST_HALF_BIT_TIME;
            r_cfg.byte_time     <= RST_BYTE_TIME;
            r_cfg.sync_gap      <= RST_SYNC_GAP;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_BIT_TIME:      r_cfg.bit_time      <= i_cfg_data[9:0];
                REG_HALF_BIT_TIME: r_cfg.half_bit_time <= i_cfg_data[8:0];
                REG_BYTE_TIME:     r_cfg.byte_time     <= i_cfg_data[11:0];
                REG_SYNC_GAP:      r_cfg.sync_gap      <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* rtl/lfbe_core.sv */
// Frame phase machine of the LANC frame bit engine: tick timing, command
// bit sending and reply sampling. Depends on lfbe_pkg.
module lfbe_core
    import lfbe_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_step,
    input  t_in_item  i_item,
    input  t_cfg      i_cfg,
    output t_out_item o_result
);

    t_phase                 r_phase, n_phase;
    logic [ELAPSED_W-1:0]   r_elapsed, n_elapsed;
    logic [BIT_INDEX_W-1:0] r_bit_index, n_bit_index;
    logic [TX_WORD_W-1:0]   r_tx_word, n_tx_word;
    logic [RX_WORD_W-1:0]   r_rx_word, n_rx_word;

    logic [ELAPSED_W-1:0]   w_tick;
    logic [2:0]             w_bit;
    logic [13:0]            w_bit_deadline;
    logic [13:0]            w_stop_deadline;
    logic [14:0]            w_rx_deadline;
    logic [16:0]            w_slot_sum;
    logic [1:0]             w_action;
    logic                   w_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_SEARCH;
            r_elapsed   <= '0;
            r_bit_index <= '0;
            r_tx_word   <= '0;
            r_rx_word   <= '0;
        end else if (i_step) begin
            r_phase     <= n_phase;
            r_elapsed   <= n_elapsed;
            r_bit_index <= n_bit_index;
            r_tx_word   <= n_tx_word;
            r_rx_word   <= n_rx_word;
        end
    end

    assign w_tick          = (r_elapsed == ELAPSED_MAX) ? r_elapsed : r_elapsed + 1'b1;
    assign w_bit           = r_bit_index[2:0];
    assign w_bit_deadline  = 14'(4'({1'b0, w_bit} + 4'd1)) * 14'(i_cfg.bit_time);
    assign w_stop_deadline = 14'(STOP_BIT_NUM) * 14'(i_cfg.bit_time);
    assign w_rx_deadline   = 15'(w_bit_deadline) + 15'(i_cfg.half_bit_time);
    assign w_slot_sum      = 17'(w_tick) + 17'(i_cfg.half_bit_time);

    always_comb begin
        n_phase     = r_phase;
        n_elapsed   = r_elapsed;
        n_bit_index = r_bit_index;
        n_tx_word   = r_tx_word;
        n_rx_word   = r_rx_word;
        w_action    = ACT_NONE;
        w_done      = 1'b0;
        case (r_phase)
            PH_SEARCH: begin
                n_elapsed = i_item.line_level ? w_tick : '0;
                if (n_elapsed > i_cfg.sync_gap) begin
                    n_tx_word = i_item.command_word;
                    n_phase   = PH_WAIT_START;
                end
            end
            PH_WAIT_START: begin
                if (!i_item.line_level) begin
                    n_bit_index = '0;
                    n_elapsed   = '0;
                    n_rx_word   = '0;
                    n_phase     = PH_TX_BIT;
                end
            end
            PH_TX_BIT: begin
                n_elapsed = w_tick;
                if (w_tick >= 16'(w_bit_deadline)) begin
                    w_action    = r_tx_word[r_bit_index[3:0]] ? ACT_ONE : ACT_ZERO;
                    n_bit_index = r_bit_index + 1'b1;
                    if (w_bit == 3'd7) begin
                        n_phase = PH_TX_STOP;
                    end
                end
            end
            PH_TX_STOP: begin
                n_elapsed = w_tick;
                if (w_tick >= 16'(w_stop_deadline)) begin
                    w_action = ACT_IDLE;
                    n_phase  = PH_WAIT_NEXT;
                end
            end
            PH_WAIT_NEXT: begin
                n_elapsed = w_tick;
                if ((w_slot_sum > 17'(i_cfg.byte_time)) && !i_item.line_level) begin
                    n_elapsed = '0;
                    n_phase   = (r_bit_index >= BIT_INDEX_W'(TX_BITS)) ? PH_RX_BIT : PH_TX_BIT;
                end
            end
            PH_RX_BIT: begin
                n_elapsed = w_tick;
                if (w_tick >= 16'(w_rx_deadline)) begin
                    if (i_item.line_level && (r_bit_index[6:5] == 2'b01)) begin
                        n_rx_word[r_bit_index[4:0]] = 1'b1;
                    end
                    n_bit_index = r_bit_index + 1'b1;
                    if (w_bit == 3'd7) begin
                        if (n_bit_index >= BIT_INDEX_W'(FRAME_BITS)) begin
                            w_done  = 1'b1;
                            n_phase = PH_SEARCH;
                        end else begin
                            n_phase = PH_WAIT_NEXT;
                        end
                    end
                end
            end
            default: begin
                n_phase = PH_SEARCH;
            end
        endcase
    end

    assign o_result.line_action = w_action;
    assign o_result.frame_done  = w_done;
    assign o_result.reply_data  = w_done ? n_rx_word : '0;

endmodule

/* rtl/lfbe_out_stage.sv */
// Result register of the LANC frame bit engine: holds one item until the
// receiver takes it. Depends on lfbe_pkg.
module lfbe_out_stage
    import lfbe_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_load,
    input  t_out_item i_item,
    input  logic      i_stall,
    output logic      o_valid,
    output t_out_item o_item
);

    logic      r_valid;
    t_out_item r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_load | (r_valid & i_stall);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule
